// ----- rtl/rars_pkg.sv -----
// ----------------------------------------------------------------------------
// rars_pkg
// Shared widths, command codes and the command and status structs that
// join the range assign / range sum controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rars_pkg;

    // Field widths of the words on the two channels.
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 16;
    localparam int VAL_W   = 16;
    localparam int SUM_W   = 32;
    localparam int LC_W    = 17;

    // Default tree capacity and the leaf count after reset.
    localparam int MAX_LEAVES_DEF = 65536;
    localparam logic [LC_W-1:0] LC_RESET = 17'h10000;

    // Command codes of the input word.
    localparam logic [CMD_W-1:0] CMD_ASSIGN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUM    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ROOT_CLR,
        OP_PATH_INIT,
        OP_PUSH_RD,
        OP_PUSH_WSELF,
        OP_PUSH_WC0,
        OP_PUSH_WC1,
        OP_PUSH_ADV,
        OP_WALK_INIT,
        OP_WL_TAG,
        OP_WL_RD,
        OP_WL_ACC,
        OP_WR_TAG,
        OP_WR_RD,
        OP_WR_ACC,
        OP_W_SHIFT,
        OP_RB_INIT,
        OP_RB_RD,
        OP_RB_RDC0,
        OP_RB_HOLD,
        OP_RB_WR,
        OP_RB_ADV,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic pending;    // last node read carries a pending fill
        logic h_one;      // height counter is one
        logic h_top;      // height counter is at the root height
        logic path_r;     // working on the right boundary path
        logic walk_done;  // left walk index has met the right one
        logic wl_odd;
        logic wr_odd;
        logic is_assign;
        logic is_clear;
        logic bad;        // command rejected
        logic out_free;   // output register can take a word
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- rtl/rars_ctrl.sv -----
// ----------------------------------------------------------------------------
// rars_ctrl
// Sequencer for one command: push pending fills down both boundary paths,
// walk the covering nodes, rebuild the boundary paths after an assign.
// ----------------------------------------------------------------------------
`default_nettype none

module rars_ctrl
    import rars_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE,
        S_PUSH_RD, S_PUSH_CHK, S_PUSH_WS, S_PUSH_WC0, S_PUSH_WC1, S_PUSH_ADV,
        S_W_L, S_W_LA, S_W_R, S_W_RA, S_W_SH,
        S_RB_RD, S_RB_CHK, S_RB_C1, S_RB_WR, S_RB_ADV,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    t_dp_op n_op;

    // Next state and the datapath operation of this cycle.
    always_comb begin
        n_state = r_state;
        n_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = OP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_clear) begin
                    n_op    = OP_ROOT_CLR;
                    n_state = S_DONE;
                end else if (i_sts.bad) begin
                    n_state = S_DONE;
                end else begin
                    n_op    = OP_PATH_INIT;
                    n_state = S_PUSH_RD;
                end
            end
            S_PUSH_RD: begin
                n_op    = OP_PUSH_RD;
                n_state = S_PUSH_CHK;
            end
            S_PUSH_CHK: begin
                n_state = i_sts.pending ? S_PUSH_WS : S_PUSH_ADV;
            end
            S_PUSH_WS: begin
                n_op    = OP_PUSH_WSELF;
                n_state = S_PUSH_WC0;
            end
            S_PUSH_WC0: begin
                n_op    = OP_PUSH_WC0;
                n_state = S_PUSH_WC1;
            end
            S_PUSH_WC1: begin
                n_op    = OP_PUSH_WC1;
                n_state = S_PUSH_ADV;
            end
            S_PUSH_ADV: begin
                if (i_sts.h_one && i_sts.path_r) begin
                    n_op    = OP_WALK_INIT;
                    n_state = S_W_L;
                end else begin
                    n_op    = OP_PUSH_ADV;
                    n_state = S_PUSH_RD;
                end
            end
            S_W_L: begin
                if (i_sts.walk_done) begin
                    if (i_sts.is_assign) begin
                        n_op    = OP_RB_INIT;
                        n_state = S_RB_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (i_sts.wl_odd) begin
                    n_op    = i_sts.is_assign ? OP_WL_TAG : OP_WL_RD;
                    n_state = i_sts.is_assign ? S_W_R : S_W_LA;
                end else begin
                    n_state = S_W_R;
                end
            end
            S_W_LA: begin
                n_op    = OP_WL_ACC;
                n_state = S_W_R;
            end
            S_W_R: begin
                if (i_sts.wr_odd) begin
                    n_op    = i_sts.is_assign ? OP_WR_TAG : OP_WR_RD;
                    n_state = i_sts.is_assign ? S_W_SH : S_W_RA;
                end else begin
                    n_state = S_W_SH;
                end
            end
            S_W_RA: begin
                n_op    = OP_WR_ACC;
                n_state = S_W_SH;
            end
            S_W_SH: begin
                n_op    = OP_W_SHIFT;
                n_state = S_W_L;
            end
            S_RB_RD: begin
                n_op    = OP_RB_RD;
                n_state = S_RB_CHK;
            end
            S_RB_CHK: begin
                if (i_sts.pending) begin
                    n_state = S_RB_ADV;
                end else begin
                    n_op    = OP_RB_RDC0;
                    n_state = S_RB_C1;
                end
            end
            S_RB_C1: begin
                n_op    = OP_RB_HOLD;
                n_state = S_RB_WR;
            end
            S_RB_WR: begin
                n_op    = OP_RB_WR;
                n_state = S_RB_ADV;
            end
            S_RB_ADV: begin
                if (i_sts.h_top && i_sts.path_r) begin
                    n_state = S_DONE;
                end else begin
                    n_op    = OP_RB_ADV;
                    n_state = S_RB_RD;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd.op   = n_op;

endmodule

`default_nettype wire

// ----- rtl/rars_dp.sv -----
// ----------------------------------------------------------------------------
// rars_dp
// Datapath: node memory holding a sum and a pending fill per tree node,
// boundary path and walk indices, the range accumulator and the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module rars_dp
    import rars_pkg::*;
#(
    parameter int MAX_LEAVES = MAX_LEAVES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_sts               o_sts,
    input  wire logic [CMD_W-1:0] i_cmd_code,
    input  wire logic [IDX_W-1:0] i_range_low,
    input  wire logic [IDX_W-1:0] i_range_high,
    input  wire logic [VAL_W-1:0] i_fill_value,
    input  wire logic             i_cfg_we,
    input  wire logic [LC_W-1:0]  i_cfg_data,
    input  wire logic             i_out_stall,
    output logic                  o_out_valid,
    output logic [SUM_W-1:0]      o_range_sum,
    output logic                  o_status
);

    // Tree of 2**L leaves, heap numbered from node 1.
    localparam int L  = (MAX_LEAVES < 2) ? 1 : $clog2(MAX_LEAVES);
    localparam int SW = VAL_W + L;
    localparam int EW = 1 + VAL_W + SW;
    localparam int AW = L + 1;
    localparam int HW = $clog2(L + 2);

    logic [EW-1:0]    r_mem [2**AW];
    logic [EW-1:0]    r_rdata;
    logic             r_rd_root;
    logic             r_root_clr;
    logic [LC_W-1:0]  r_lc;
    logic [CMD_W-1:0] r_cmd;
    logic             r_bad;
    logic [L-1:0]     r_l, r_r;
    logic [VAL_W-1:0] r_v;
    logic [HW-1:0]    r_h;
    logic             r_path;
    logic [AW:0]      r_wl, r_wr;
    logic [AW-1:0]    r_node;
    logic [SW-1:0]    r_acc, r_hold;
    logic             r_ovalid;
    logic [SUM_W-1:0] r_osum;
    logic             r_ostat;

    logic [EW-1:0]    ent;
    logic [L-1:0]     path_leaf;
    logic [AW-1:0]    path_node, wr_node;
    logic [HW-1:0]    h_child;
    logic             rd_en, we;
    logic [AW-1:0]    rd_addr, waddr;
    logic [EW-1:0]    wdata;
    logic [31:0]      eff_lc, lo32, hi32;
    logic             in_ok;
    logic [AW:0]      wr_dec;
    logic [63:0]      acc64;

    // Value of a subtree: a pending fill times the leaf count, else its sum.
    function automatic logic [SW-1:0] f_eval(input logic [EW-1:0] e, input logic [HW-1:0] h);
        logic [SW-1:0] v;
        v = SW'(e[EW-2 -: VAL_W]);
        return e[EW-1] ? (v << h) : e[SW-1:0];
    endfunction

    // The root reads as "pending zero" after reset, clear or a config write.
    assign ent = r_rd_root ? {1'b1, {VAL_W{1'b0}}, {SW{1'b0}}} : r_rdata;

    assign path_leaf = r_path ? r_r : r_l;
    assign path_node = AW'({1'b1, path_leaf} >> r_h);
    assign wr_dec    = r_wr - 1'b1;
    assign wr_node   = wr_dec[AW-1:0];
    assign h_child   = r_h - 1'b1;

    // Range check against the clamped leaf count.
    assign eff_lc = (32'(r_lc) > 32'(MAX_LEAVES)) ? 32'(MAX_LEAVES) : 32'(r_lc);
    assign lo32   = 32'(i_range_low);
    assign hi32   = 32'(i_range_high);
    assign in_ok  = (lo32 <= hi32) && (hi32 < eff_lc);

    // Memory port selection per operation.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = path_node;
        we      = 1'b0;
        waddr   = r_node;
        wdata   = {1'b1, ent[EW-2 -: VAL_W], {SW{1'b0}}};
        unique case (i_cmd.op)
            OP_PUSH_RD, OP_RB_RD: begin
                rd_en = 1'b1;
            end
            OP_WL_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_wl[AW-1:0];
            end
            OP_WR_RD: begin
                rd_en   = 1'b1;
                rd_addr = wr_node;
            end
            OP_RB_RDC0: begin
                rd_en   = 1'b1;
                rd_addr = {r_node[AW-2:0], 1'b0};
            end
            OP_RB_HOLD: begin
                rd_en   = 1'b1;
                rd_addr = {r_node[AW-2:0], 1'b1};
            end
            OP_PUSH_WSELF: begin
                we    = 1'b1;
                wdata = {1'b0, {VAL_W{1'b0}}, f_eval(ent, r_h)};
            end
            OP_PUSH_WC0: begin
                we    = 1'b1;
                waddr = {r_node[AW-2:0], 1'b0};
            end
            OP_PUSH_WC1: begin
                we    = 1'b1;
                waddr = {r_node[AW-2:0], 1'b1};
            end
            OP_WL_TAG: begin
                we    = 1'b1;
                waddr = r_wl[AW-1:0];
                wdata = {1'b1, r_v, {SW{1'b0}}};
            end
            OP_WR_TAG: begin
                we    = 1'b1;
                waddr = wr_node;
                wdata = {1'b1, r_v, {SW{1'b0}}};
            end
            OP_RB_WR: begin
                we    = 1'b1;
                wdata = {1'b0, {VAL_W{1'b0}}, r_hold + f_eval(ent, h_child)};
            end
            default: begin
            end
        endcase
    end

    // Node memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_clr <= 1'b1;
            r_rd_root  <= 1'b0;
            r_lc       <= LC_RESET;
            r_ovalid   <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rd_root <= r_root_clr && (rd_addr == AW'(1));
            end
            if (i_cfg_we) begin
                r_lc       <= i_cfg_data;
                r_root_clr <= 1'b1;
            end else if (i_cmd.op == OP_ROOT_CLR) begin
                r_root_clr <= 1'b1;
            end else if (we && (waddr == AW'(1))) begin
                r_root_clr <= 1'b0;
            end
            if (i_cmd.op == OP_OUT) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Saturate the range total to the output width.
    assign acc64 = 64'(r_acc);

    // Working registers of the current command.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_cmd <= i_cmd_code;
                r_bad <= (i_cmd_code != CMD_CLEAR) &&
                         (!in_ok || ((i_cmd_code != CMD_ASSIGN) && (i_cmd_code != CMD_SUM)));
                r_l   <= L'(lo32);
                r_r   <= L'(hi32);
                r_v   <= i_fill_value;
                r_acc <= '0;
            end
            OP_PATH_INIT: begin
                r_path <= 1'b0;
                r_h    <= HW'(L);
            end
            OP_PUSH_RD, OP_RB_RD: begin
                r_node <= path_node;
            end
            OP_PUSH_ADV: begin
                if (r_h == HW'(1)) begin
                    r_path <= 1'b1;
                    r_h    <= HW'(L);
                end else begin
                    r_h <= h_child;
                end
            end
            OP_WALK_INIT: begin
                r_wl <= {1'b0, 1'b1, r_l};
                r_wr <= {1'b0, 1'b1, r_r} + 1'b1;
                r_h  <= '0;
            end
            OP_WL_TAG: begin
                r_wl <= r_wl + 1'b1;
            end
            OP_WL_ACC: begin
                r_acc <= r_acc + f_eval(ent, r_h);
                r_wl  <= r_wl + 1'b1;
            end
            OP_WR_TAG: begin
                r_wr <= wr_dec;
            end
            OP_WR_ACC: begin
                r_acc <= r_acc + f_eval(ent, r_h);
                r_wr  <= wr_dec;
            end
            OP_W_SHIFT: begin
                r_wl <= r_wl >> 1;
                r_wr <= r_wr >> 1;
                r_h  <= r_h + 1'b1;
            end
            OP_RB_INIT: begin
                r_path <= 1'b0;
                r_h    <= HW'(1);
            end
            OP_RB_HOLD: begin
                r_hold <= f_eval(ent, h_child);
            end
            OP_RB_ADV: begin
                if (r_h == HW'(L)) begin
                    r_path <= 1'b1;
                    r_h    <= HW'(1);
                end else begin
                    r_h <= r_h + 1'b1;
                end
            end
            OP_OUT: begin
                r_ostat <= r_bad;
                if ((r_cmd == CMD_SUM) && !r_bad) begin
                    r_osum <= (acc64 > 64'hFFFF_FFFF) ? '1 : acc64[SUM_W-1:0];
                end else begin
                    r_osum <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Status toward the controller.
    assign o_sts.pending   = ent[EW-1];
    assign o_sts.h_one     = (r_h == HW'(1));
    assign o_sts.h_top     = (r_h == HW'(L));
    assign o_sts.path_r    = r_path;
    assign o_sts.walk_done = (r_wl >= r_wr);
    assign o_sts.wl_odd    = r_wl[0];
    assign o_sts.wr_odd    = r_wr[0];
    assign o_sts.is_assign = (r_cmd == CMD_ASSIGN);
    assign o_sts.is_clear  = (r_cmd == CMD_CLEAR);
    assign o_sts.bad       = r_bad;
    assign o_sts.out_free  = !r_ovalid || !i_out_stall;

    assign o_out_valid = r_ovalid;
    assign o_range_sum = r_osum;
    assign o_status    = r_ostat;

`ifndef SYNTHESIS
    // The node memory never reads and writes in the same cycle.
    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && we))
        else $error("node memory read and write collide");

    // Node zero is outside the heap and is never written.
    a_no_node0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (waddr != '0))
        else $error("write to node zero");

    // A rejected word carries a zero sum.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostat) |-> (r_osum == '0))
        else $error("rejected word with nonzero sum");
`endif

endmodule

`default_nettype wire

// ----- rtl/range_assign_range_sum_tree_top.sv -----
// A word is taken and decoded, pending fills are pushed down the two
// boundary paths, the covering nodes are walked level by level, and
// after an assign both boundary paths are rebuilt from the leaves up.
// Words are taken one at a time: the input stalls until the result of
// the current word has been handed to the output register.
// Reset is synchronous; the tree starts as one pending zero at the root, so
// no clearing pass over the node memory is needed.
// ----------------------------------------------------------------------------
// range_assign_range_sum_tree_top
// Array of leaf values with range assign, range sum and clear, held in a
// segment tree with lazily pushed fills.
// ----------------------------------------------------------------------------
`default_nettype none

module range_assign_range_sum_tree_top
    import rars_pkg::*;
#(
    parameter int MAX_LEAVES = MAX_LEAVES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [CMD_W-1:0] i_cmd,
    input  wire logic [IDX_W-1:0] i_range_low,
    input  wire logic [IDX_W-1:0] i_range_high,
    input  wire logic [VAL_W-1:0] i_fill_value,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [SUM_W-1:0]      o_range_sum,
    output logic                  o_status,
    input  wire logic             i_cfg_we,
    input  wire logic [LC_W-1:0]  i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    rars_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    rars_dp #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_cmd_code   (i_cmd),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_fill_value (i_fill_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_range_sum  (o_range_sum),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire

// ----- test/range_assign_range_sum_tree_top_tb.sv -----
// ----------------------------------------------------------------------------
// range_assign_range_sum_tree_top_tb
// Drives assign, sum and clear words into the range tree and checks every
// result word against a flat array model of the leaves. Several leaf counts
// are used, and both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module range_assign_range_sum_tree_top_tb;
    import rars_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEAVES    = MAX_LEAVES_DEF;
    localparam int DRAIN_CYC = 500;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [SUM_W-1:0] range_sum;
        logic             status;
    } t_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [CMD_W-1:0] i_cmd;
    logic [IDX_W-1:0] i_range_low;
    logic [IDX_W-1:0] i_range_high;
    logic [VAL_W-1:0] i_fill_value;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [SUM_W-1:0] o_range_sum;
    logic             o_status;
    logic             i_cfg_we;
    logic [LC_W-1:0]  i_cfg_data;

    // Flat copy of the array and the leaf count in force.
    logic [VAL_W-1:0] leaf_val [0:LEAVES-1];
    int unsigned      leaf_count_eff;
    t_result          pending_results[$];

    int  fail_count = 0;
    int  words_sent = 0;
    int  words_checked = 0;
    bit  quiet_tail = 0;
    bit  long_hold_req = 0;

    range_assign_range_sum_tree_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_fill_value (i_fill_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_range_sum  (o_range_sum),
        .o_status     (o_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock with a 4 ns period, first rising edge after time zero.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Work out the result of one command word and apply it to the array.
    function automatic t_result predict_range_cmd(logic [CMD_W-1:0] cmd,
            logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi, logic [VAL_W-1:0] val);
        t_result res;
        longint  total;
        bit      ok;
        res.range_sum = '0;
        res.status = 1'b0;
        total = 0;
        ok = (lo <= hi) && (int'(hi) < leaf_count_eff);
        if (cmd == CMD_CLEAR) begin
            for (int i = 0; i < LEAVES; i++) leaf_val[i] = '0;
        end else if (cmd == CMD_UNUSED || !ok) begin
            res.status = 1'b1;
        end else if (cmd == CMD_ASSIGN) begin
            for (int i = lo; i <= hi; i++) leaf_val[i] = val;
        end else begin
            for (int i = lo; i <= hi; i++) total += leaf_val[i];
            if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
            res.range_sum = total[SUM_W-1:0];
        end
        return res;
    endfunction

    // Offer one word, wait for it to be taken, then maybe idle a burst.
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] lo,
            logic [IDX_W-1:0] hi, logic [VAL_W-1:0] val);
        int gap;
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_range_low  <= lo;
        i_range_high <= hi;
        i_fill_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(predict_range_cmd(cmd, lo, hi, val));
        words_sent++;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every expected word has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // Write the leaf count while the block is idle; this also clears the array.
    task automatic write_leaf_count(logic [LC_W-1:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        leaf_count_eff = (value > LEAVES) ? LEAVES : value;
        for (int i = 0; i < LEAVES; i++) leaf_val[i] = '0;
        @(posedge i_clk);
    endtask

    // Random word: mostly valid short ranges, some wide, some broken.
    task automatic send_random_word();
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] lo, hi;
        int unsigned      lim, pick, span;
        pick = $urandom_range(0, 99);
        lim = (leaf_count_eff == 0) ? 1 : leaf_count_eff;
        if (pick < 45) cmd = CMD_ASSIGN;
        else if (pick < 90) cmd = CMD_SUM;
        else if (pick < 95) cmd = CMD_CLEAR;
        else cmd = CMD_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            lo = IDX_W'($urandom_range(0, lim - 1));
            span = $urandom_range(0, 63);
            hi = IDX_W'((lo + span >= lim) ? lim - 1 : lo + span);
        end else if (pick < 85) begin
            lo = '0;
            hi = IDX_W'(lim - 1);
        end else begin
            lo = IDX_W'($urandom);
            hi = IDX_W'($urandom);
        end
        send_word(cmd, lo, hi, VAL_W'($urandom));
    endtask

    // Result checker: compare each taken word with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: sum %0h status %0b",
                       o_range_sum, o_status);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                words_checked++;
                if (o_range_sum !== want.range_sum) begin
                    $error("range_sum: expected %0h, actual %0h",
                           want.range_sum, o_range_sum);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0b, actual %0b", want.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stall bursts, and one long hold on request.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                i_out_stall <= 1'b1;
                repeat (3000) @(posedge i_clk);
                i_out_stall <= 1'b0;
                long_hold_req = 0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Extremes of the fields, every command and each named special case.
    task automatic test_directed();
        send_word(CMD_SUM, 0, 16'hFFFF, 0);
        send_word(CMD_ASSIGN, 0, 16'hFFFF, 16'hFFFF);
        send_word(CMD_SUM, 0, 16'hFFFF, 0);
        send_word(CMD_SUM, 16'hFFFF, 16'hFFFF, 0);
        send_word(CMD_ASSIGN, 16'h5555, 16'hAAAA, 16'h0001);
        send_word(CMD_SUM, 16'h5554, 16'hAAAB, 0);
        send_word(CMD_SUM, 0, 0, 0);
        send_word(CMD_ASSIGN, 9, 3, 16'h1234);
        send_word(CMD_SUM, 9, 3, 0);
        send_word(CMD_UNUSED, 0, 10, 16'hFFFF);
        send_word(CMD_CLEAR, 16'hFFFF, 0, 16'hFFFF);
        send_word(CMD_SUM, 0, 16'hFFFF, 0);
        send_word(CMD_ASSIGN, 100, 100, 16'h8000);
        send_word(CMD_SUM, 99, 101, 0);
        drain_results();
        write_leaf_count(0);
        send_word(CMD_ASSIGN, 0, 0, 7);
        send_word(CMD_SUM, 0, 0, 0);
        send_word(CMD_CLEAR, 0, 0, 0);
        write_leaf_count(1);
        send_word(CMD_ASSIGN, 0, 0, 16'hFFFF);
        send_word(CMD_SUM, 0, 1, 0);
        send_word(CMD_SUM, 0, 0, 0);
        write_leaf_count(17'h1FFFF);
        send_word(CMD_SUM, 0, 16'hFFFF, 0);
        send_word(CMD_ASSIGN, 16'hFFFE, 16'hFFFF, 3);
        send_word(CMD_SUM, 16'hFFF0, 16'hFFFF, 0);
        drain_results();
    endtask

    // A run of random words at one leaf count.
    task automatic test_random_phase(logic [LC_W-1:0] lc, int count);
        write_leaf_count(lc);
        repeat (count) send_random_word();
        drain_results();
    endtask

    // Long receiver hold so the block backs up onto its input.
    task automatic test_backpressure();
        long_hold_req = 1;
        repeat (30) send_random_word();
        drain_results();
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_cmd        <= CMD_ASSIGN;
        i_range_low  <= '0;
        i_range_high <= '0;
        i_fill_value <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_data   <= '0;
        leaf_count_eff = LEAVES;
        for (int i = 0; i < LEAVES; i++) leaf_val[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(17'd17, 80);
        test_random_phase(17'd1000, 80);
        test_backpressure();
        test_random_phase(17'd1, 30);
        test_random_phase(17'h1FFFF, 80);
        quiet_tail = 1;
        test_random_phase(LC_RESET, 150);

        $display("Sent %0d command words and checked %0d results over several leaf counts,",
                 words_sent, words_checked);
        $display("with random idling on both channels and one long output hold.");
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/rars_pkg.sv
rtl/rars_ctrl.sv
rtl/rars_dp.sv
rtl/range_assign_range_sum_tree_top.sv
test/range_assign_range_sum_tree_top_tb.sv
